@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/tfd_pkg.sv @@
package tfd_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int STATUS_BITS = 32;

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int MODE_W   = 3;
    localparam int HANDLE_W = 8;
    localparam int VALUE_W  = 32;
    localparam int CODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OR       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

    localparam logic [CODE_W-1:0] CODE_OK        = 2'd0;
    localparam logic [CODE_W-1:0] CODE_NOT_FOUND = 2'd1;
    localparam logic [CODE_W-1:0] CODE_FULL      = 2'd2;
    localparam logic [CODE_W-1:0] CODE_NONE      = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic advance;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
    } t_dp_stat;

endpackage

@@ rtl/core/tfd_ctrl.sv @@
`include "assert_macros.svh"

module tfd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tfd_pkg::t_dp_cmd   o_cmd,
    input  tfd_pkg::t_dp_stat  i_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd.capture = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.done) begin
                    o_cmd.advance = 1'b1;
                end else if (w_out_free) begin
                    // hold the decision until the output register frees up
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_CLK(a_accept_starts_scan, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> (r_state == S_SCAN), "accept did not start a scan")
    `ASSERT_CLK(a_commit_fills_out, i_clk, i_rst_n,
        o_cmd.commit |=> r_out_valid, "commit did not present a result")
    `ASSERT_CLK(a_scan_holds, i_clk, i_rst_n,
        (r_state == S_SCAN && !i_stat.done) |=> (r_state == S_SCAN), "scan left early")

endmodule

@@ rtl/core/tfd_datapath.sv @@
`include "assert_macros.svh"

module tfd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfd_pkg::t_dp_cmd                    i_cmd,
    output tfd_pkg::t_dp_stat                   o_stat,
    input  logic [tfd_pkg::MODE_W-1:0]          i_mode,
    input  logic [tfd_pkg::HANDLE_W-1:0]        i_task_handle,
    input  logic [tfd_pkg::VALUE_W-1:0]         i_status_value,
    output logic [tfd_pkg::CODE_W-1:0]          o_result_code,
    output logic [tfd_pkg::HANDLE_W-1:0]        o_served_handle,
    output logic [tfd_pkg::VALUE_W-1:0]         o_served_status
);

    // Slot table
    logic [tfd_pkg::HANDLE_W-1:0]    r_slot_handle [tfd_pkg::SLOT_COUNT];
    logic [tfd_pkg::STATUS_BITS-1:0] r_slot_status [tfd_pkg::SLOT_COUNT];

    logic [tfd_pkg::CNT_W-1:0]       r_used, n_used;
    logic [tfd_pkg::SLOT_W-1:0]      r_resume, n_resume;
    logic                            r_restart, n_restart;

    // Captured transaction and scan index
    logic [tfd_pkg::MODE_W-1:0]      r_mode;
    logic [tfd_pkg::HANDLE_W-1:0]    r_handle;
    logic [tfd_pkg::STATUS_BITS-1:0] r_value;
    logic [tfd_pkg::CNT_W-1:0]       r_idx;

    logic [tfd_pkg::CODE_W-1:0]      r_code, n_code;
    logic [tfd_pkg::HANDLE_W-1:0]    r_sh, n_sh;
    logic [tfd_pkg::VALUE_W-1:0]     r_ss, n_ss;

    logic [tfd_pkg::SLOT_W-1:0]      w_addr;
    logic [tfd_pkg::HANDLE_W-1:0]    w_rd_handle;
    logic [tfd_pkg::STATUS_BITS-1:0] w_rd_status;
    logic [tfd_pkg::CNT_W-1:0]       w_idx_next;
    logic                            w_end, w_hit, w_done;
    logic                            w_wr_reg, w_wr_status;
    logic [tfd_pkg::STATUS_BITS-1:0] w_new_status;

    assign w_addr      = r_idx[tfd_pkg::SLOT_W-1:0];
    assign w_rd_handle = r_slot_handle[w_addr];
    assign w_rd_status = r_slot_status[w_addr];
    assign w_end       = (r_idx >= r_used);
    assign w_idx_next  = tfd_pkg::CNT_W'(r_idx + 1'b1);

    always_comb begin
        case (r_mode)
            tfd_pkg::MODE_SET, tfd_pkg::MODE_OR, tfd_pkg::MODE_QUERY: begin
                w_hit  = !w_end && (w_rd_handle == r_handle);
                w_done = w_end || w_hit;
            end
            tfd_pkg::MODE_DISPATCH: begin
                w_hit  = !w_end && (w_rd_status != '0);
                w_done = w_end || w_hit;
            end
            default: begin
                w_hit  = 1'b0;
                w_done = 1'b1;
            end
        endcase
    end

    assign o_stat.done = w_done;

    // Outcome of the transaction at the scan position
    always_comb begin
        n_used       = r_used;
        n_resume     = r_resume;
        n_restart    = r_restart;
        n_code       = tfd_pkg::CODE_OK;
        n_sh         = '0;
        n_ss         = '0;
        w_wr_reg     = 1'b0;
        w_wr_status  = 1'b0;
        w_new_status = r_value;
        case (r_mode)
            tfd_pkg::MODE_REGISTER: begin
                if (r_handle == '0) begin
                    n_code = tfd_pkg::CODE_NOT_FOUND;
                end else if (r_used >= tfd_pkg::CNT_W'(tfd_pkg::SLOT_COUNT)) begin
                    n_code = tfd_pkg::CODE_FULL;
                end else begin
                    w_wr_reg = 1'b1;
                    n_used   = tfd_pkg::CNT_W'(r_used + 1'b1);
                end
            end
            tfd_pkg::MODE_SET, tfd_pkg::MODE_OR: begin
                if (w_hit) begin
                    w_wr_status  = 1'b1;
                    w_new_status = (r_mode == tfd_pkg::MODE_OR) ? (w_rd_status | r_value)
                                                                : r_value;
                    n_restart    = 1'b1;
                end else begin
                    n_code = tfd_pkg::CODE_NOT_FOUND;
                end
            end
            tfd_pkg::MODE_DISPATCH: begin
                if (w_hit) begin
                    n_sh         = w_rd_handle;
                    n_ss         = tfd_pkg::VALUE_W'(w_rd_status);
                    w_wr_status  = 1'b1;
                    w_new_status = '0;
                    n_resume     = (w_idx_next >= r_used) ? '0
                                                          : tfd_pkg::SLOT_W'(w_idx_next);
                end else begin
                    n_code   = tfd_pkg::CODE_NONE;
                    n_resume = '0;
                end
            end
            tfd_pkg::MODE_QUERY: begin
                if (w_hit) begin
                    n_sh = w_rd_handle;
                    n_ss = tfd_pkg::VALUE_W'(w_rd_status);
                end else begin
                    n_code = tfd_pkg::CODE_NOT_FOUND;
                end
            end
            default: begin
                n_code = tfd_pkg::CODE_NOT_FOUND;
            end
        endcase
    end

    // Table writes; entries at or above the fill count are never read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_wr_reg) begin
            r_slot_handle[r_used[tfd_pkg::SLOT_W-1:0]] <= r_handle;
            r_slot_status[r_used[tfd_pkg::SLOT_W-1:0]] <= r_value;
        end else if (i_cmd.commit && w_wr_status) begin
            r_slot_status[w_addr] <= w_new_status;
        end
    end

    // Transaction capture, scan index and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_handle <= i_task_handle;
            r_value  <= tfd_pkg::STATUS_BITS'(i_status_value);
            r_idx    <= (i_mode == tfd_pkg::MODE_DISPATCH && !r_restart)
                        ? tfd_pkg::CNT_W'(r_resume) : '0;
        end else if (i_cmd.advance) begin
            r_idx <= w_idx_next;
        end
        if (i_cmd.commit) begin
            r_code <= n_code;
            r_sh   <= n_sh;
            r_ss   <= n_ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_resume  <= '0;
            r_restart <= 1'b0;
        end else if (i_cmd.commit) begin
            r_used    <= n_used;
            r_resume  <= n_resume;
            r_restart <= n_restart;
        end
    end

    assign o_result_code   = r_code;
    assign o_served_handle = r_sh;
    assign o_served_status = r_ss;

    `ASSERT_CLK(a_used_bound, i_clk, i_rst_n,
        r_used <= tfd_pkg::CNT_W'(tfd_pkg::SLOT_COUNT), "fill count past table size")
    `ASSERT_CLK(a_resume_bound, i_clk, i_rst_n,
        (r_resume == '0) || (tfd_pkg::CNT_W'(r_resume) < r_used), "resume slot past fill count")
    `ASSERT_CLK(a_advance_step, i_clk, i_rst_n,
        i_cmd.advance |=> (r_idx == tfd_pkg::CNT_W'($past(r_idx) + 1'b1)), "scan index skipped")

endmodule

@@ rtl/core/task_flag_dispatcher.sv @@
// Flow: an accepted transaction is captured, then its slot scan runs, then the table update
//   and the result are committed together; register and unknown modes scan no slots.
// Handshake: one transaction at a time, as a new one is taken only when idle; the slot scan
//   examines one table slot per cycle, and a result held by the receiver stalls the commit.
// Reset: synchronous, active low; clears fill count, resume slot, restart flag and
//   handshake state at once. Table contents are not cleared and are never read unfilled.
module task_flag_dispatcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tfd_pkg::MODE_W-1:0]      i_mode,
    input  logic [tfd_pkg::HANDLE_W-1:0]    i_task_handle,
    input  logic [tfd_pkg::VALUE_W-1:0]     i_status_value,

    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tfd_pkg::CODE_W-1:0]      o_result_code,
    output logic [tfd_pkg::HANDLE_W-1:0]    o_served_handle,
    output logic [tfd_pkg::VALUE_W-1:0]     o_served_status
);

    // The controller accepts a transaction only when idle, then walks the
    // datapath through the slot scan one slot per cycle. Once the datapath
    // reports the scan finished, commit the table update and the result in
    // the same cycle, but only when the output register is empty or being
    // drained; otherwise hold the scan position until it frees up.
    tfd_pkg::t_dp_cmd  w_cmd;
    tfd_pkg::t_dp_stat w_stat;

    tfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // Datapath: slot table, fill count, resume slot, restart flag, the
    // captured transaction and the result register that feeds the ports.
    tfd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (i_mode),
        .i_task_handle   (i_task_handle),
        .i_status_value  (i_status_value),
        .o_result_code   (o_result_code),
        .o_served_handle (o_served_handle),
        .o_served_status (o_served_status)
    );

endmodule

@@ tb/sv/tb_task_flag_dispatcher.sv @@
module tb_task_flag_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result of the dispatcher.
    typedef struct packed {
        logic [tfd_pkg::CODE_W-1:0]   code;
        logic [tfd_pkg::HANDLE_W-1:0] handle;
        logic [tfd_pkg::VALUE_W-1:0]  status;
    } t_outcome;

    // Scoreboard: keeps its own copy of the task table, predicts the outcome of every
    // accepted request and compares each returned result with the oldest prediction.
    class task_table_scoreboard;
        logic [tfd_pkg::HANDLE_W-1:0] slot_handle [tfd_pkg::SLOT_COUNT];
        logic [tfd_pkg::VALUE_W-1:0]  slot_status [tfd_pkg::SLOT_COUNT];
        int                           used_slots;
        int                           resume_slot;
        bit                           restart_scan;
        t_outcome                     pending_outcomes [$];
        int                           errors;

        function new();
            for (int i = 0; i < tfd_pkg::SLOT_COUNT; i++) begin
                slot_handle[i] = '0;
                slot_status[i] = '0;
            end
            used_slots   = 0;
            resume_slot  = 0;
            restart_scan = 1'b0;
            errors       = 0;
        endfunction

        // First registered slot holding the handle, or -1.
        function int find_slot(logic [tfd_pkg::HANDLE_W-1:0] handle);
            int idx;
            idx = -1;
            for (int i = 0; i < used_slots && idx < 0; i++) begin
                if (slot_handle[i] == handle) idx = i;
            end
            return idx;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void note_request(logic [tfd_pkg::MODE_W-1:0] mode,
                                   logic [tfd_pkg::HANDLE_W-1:0] handle,
                                   logic [tfd_pkg::VALUE_W-1:0] value);
            t_outcome o;
            int       idx;
            int       start;
            o.code   = tfd_pkg::CODE_OK;
            o.handle = '0;
            o.status = '0;
            case (mode)
                tfd_pkg::MODE_REGISTER: begin
                    if (handle == '0) begin
                        o.code = tfd_pkg::CODE_NOT_FOUND;
                    end else if (used_slots >= tfd_pkg::SLOT_COUNT) begin
                        o.code = tfd_pkg::CODE_FULL;
                    end else begin
                        slot_handle[used_slots] = handle;
                        slot_status[used_slots] = value;
                        used_slots++;
                    end
                end
                tfd_pkg::MODE_SET, tfd_pkg::MODE_OR: begin
                    idx = find_slot(handle);
                    if (idx < 0) begin
                        o.code = tfd_pkg::CODE_NOT_FOUND;
                    end else begin
                        if (mode == tfd_pkg::MODE_SET) slot_status[idx] = value;
                        else slot_status[idx] = slot_status[idx] | value;
                        restart_scan = 1'b1;
                    end
                end
                tfd_pkg::MODE_DISPATCH: begin
                    start = restart_scan ? 0 : resume_slot;
                    idx   = -1;
                    for (int i = start; i < used_slots && idx < 0; i++) begin
                        if (slot_status[i] != '0) idx = i;
                    end
                    if (idx >= 0) begin
                        o.handle         = slot_handle[idx];
                        o.status         = slot_status[idx];
                        slot_status[idx] = '0;
                        resume_slot      = (idx + 1 >= used_slots) ? 0 : idx + 1;
                    end else begin
                        o.code      = tfd_pkg::CODE_NONE;
                        resume_slot = 0;
                    end
                end
                tfd_pkg::MODE_QUERY: begin
                    idx = find_slot(handle);
                    if (idx < 0) begin
                        o.code = tfd_pkg::CODE_NOT_FOUND;
                    end else begin
                        o.handle = slot_handle[idx];
                        o.status = slot_status[idx];
                    end
                end
                default: o.code = tfd_pkg::CODE_NOT_FOUND;
            endcase
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [tfd_pkg::CODE_W-1:0] code,
                                    logic [tfd_pkg::HANDLE_W-1:0] handle,
                                    logic [tfd_pkg::VALUE_W-1:0] status);
            t_outcome o;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual code %0d handle %0d %s %h",
                         $time, code, handle, "status", status);
                errors++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (code !== o.code) begin
                $display("%0t: result_code mismatch: expected %0d, actual %0d",
                         $time, o.code, code);
                errors++;
            end
            if (handle !== o.handle) begin
                $display("%0t: served_handle mismatch: expected %0d, actual %0d",
                         $time, o.handle, handle);
                errors++;
            end
            if (status !== o.status) begin
                $display("%0t: served_status mismatch: expected %h, actual %h",
                         $time, o.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_ready;
    logic [tfd_pkg::MODE_W-1:0]   i_mode         = '0;
    logic [tfd_pkg::HANDLE_W-1:0] i_task_handle  = '0;
    logic [tfd_pkg::VALUE_W-1:0]  i_status_value = '0;
    logic                         o_out_valid;
    logic                         i_out_ready    = 1'b0;
    logic [tfd_pkg::CODE_W-1:0]   o_result_code;
    logic [tfd_pkg::HANDLE_W-1:0] o_served_handle;
    logic [tfd_pkg::VALUE_W-1:0]  o_served_status;

    // Idle rates in percent: sender gaps and receiver stalls.
    int in_idle_pct   = 13;
    int out_stall_pct = 59;

    task_table_scoreboard sb;

    task_flag_dispatcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_task_handle   (i_task_handle),
        .i_status_value  (i_status_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_code   (o_result_code),
        .o_served_handle (o_served_handle),
        .o_served_status (o_served_status)
    );

    // 10 ns clock: low half, then high half.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: drop ready at random at the current stall rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Result monitor: check every transaction on the result channel. Values read here are
    // the ones the block saw at this edge, since all drives land as nonblocking updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_outcome(o_result_code, o_served_handle, o_served_status);
        end
    end

    // Drive one request and hold it until the block takes it. Insert a random gap first;
    // when there is no gap, keep valid high straight into the next transaction.
    task automatic send_request(input logic [tfd_pkg::MODE_W-1:0] mode,
                                input logic [tfd_pkg::HANDLE_W-1:0] handle,
                                input logic [tfd_pkg::VALUE_W-1:0] value);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_task_handle  <= handle;
        i_status_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(mode, handle, value);
    endtask

    // Hold the sender off until every predicted result has come back, with a cap.
    // Always advance at least one edge so valid is never lowered and raised in one step.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending() != 0 && waited < 20000);
    endtask

    // Random traffic. Most set, OR and query transactions aim at registered handles so that
    // they hit; the rest use any handle, zero included. Status words mix zero, single bits,
    // all ones and full random words so dispatch finds both empty and pending slots.
    task automatic run_random(input int count);
        logic [tfd_pkg::MODE_W-1:0]   mode;
        logic [tfd_pkg::HANDLE_W-1:0] handle;
        logic [tfd_pkg::VALUE_W-1:0]  value;
        int                           pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       mode = tfd_pkg::MODE_REGISTER;
            else if (pick < 28) mode = tfd_pkg::MODE_SET;
            else if (pick < 48) mode = tfd_pkg::MODE_OR;
            else if (pick < 78) mode = tfd_pkg::MODE_DISPATCH;
            else if (pick < 94) mode = tfd_pkg::MODE_QUERY;
            else mode = tfd_pkg::MODE_QUERY + tfd_pkg::MODE_W'($urandom_range(1, 3));

            if (sb.used_slots > 0 && $urandom_range(0, 99) < 80)
                handle = sb.slot_handle[$urandom_range(0, sb.used_slots - 1)];
            else
                handle = tfd_pkg::HANDLE_W'($urandom_range(0, 255));

            case ($urandom_range(0, 5))
                0:       value = '0;
                1:       value = tfd_pkg::VALUE_W'(1) << $urandom_range(0, tfd_pkg::VALUE_W - 1);
                2:       value = '1;
                default: value = $urandom;
            endcase
            send_request(mode, handle, value);
        end
    endtask

    // Hard limit on the whole run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: nothing to dispatch, every lookup misses, handle zero is refused.
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_QUERY,    8'd5,   32'h0);
        send_request(tfd_pkg::MODE_SET,      8'd5,   32'h1234_5678);
        send_request(tfd_pkg::MODE_OR,       8'd5,   32'hFFFF_FFFF);
        send_request(tfd_pkg::MODE_REGISTER, 8'd0,   32'hFFFF_FFFF);

        // Fill a few slots with extreme handles and status words, one of them idle.
        send_request(tfd_pkg::MODE_REGISTER, 8'd255, 32'hFFFF_FFFF);
        send_request(tfd_pkg::MODE_REGISTER, 8'd1,   32'h0);
        send_request(tfd_pkg::MODE_REGISTER, 8'h80,  32'h0000_0001);
        send_request(tfd_pkg::MODE_REGISTER, 8'h7F,  32'h8000_0000);

        // Before any set or OR: dispatch resumes after the last hit and wraps.
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_REGISTER, 8'd255, 32'h0000_0005);  // duplicate handle
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);

        // Duplicate handle: lookups land on the first slot holding it.
        send_request(tfd_pkg::MODE_QUERY,    8'd255, 32'h0);
        send_request(tfd_pkg::MODE_SET,      8'd1,   32'hA5A5_A5A5);
        send_request(tfd_pkg::MODE_OR,       8'd1,   32'h5A5A_5A5A);
        send_request(tfd_pkg::MODE_QUERY,    8'd1,   32'h0);
        send_request(tfd_pkg::MODE_OR,       8'h80,  32'h0);
        send_request(tfd_pkg::MODE_SET,      8'h7F,  32'h0000_0100);

        // Once restarted, dispatch scans from slot zero every time.
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);
        send_request(tfd_pkg::MODE_DISPATCH, 8'd0,   32'h0);

        // Unused mode codes.
        send_request(tfd_pkg::MODE_QUERY + 3'd1, 8'd255, 32'hFFFF_FFFF);
        send_request(tfd_pkg::MODE_QUERY + 3'd2, 8'd1,   32'h0);
        send_request(tfd_pkg::MODE_QUERY + 3'd3, 8'd0,   32'h1);

        run_random(510);
        drain_results();

        in_idle_pct   = 59;
        out_stall_pct = 13;
        run_random(510);
        drain_results();

        // Full table: top up to the last slot, then try one more.
        in_idle_pct   = 0;
        out_stall_pct = 0;
        while (sb.used_slots < tfd_pkg::SLOT_COUNT)
            send_request(tfd_pkg::MODE_REGISTER, tfd_pkg::HANDLE_W'($urandom_range(1, 255)),
                         $urandom);
        send_request(tfd_pkg::MODE_REGISTER, 8'hC3, 32'hFFFF_FFFF);
        run_random(510);
        drain_results();

        // Let any stray result show up before the verdict.
        repeat (tfd_pkg::SLOT_COUNT + 8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
